// ===== hdl/bc_pkg.sv =====
package bc_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int FIELD_WIDTH = 64;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [FIELD_WIDTH-1:0] t_field;
    typedef logic [CNT_WIDTH-1:0]   t_cnt;

    localparam t_value VAL_ZERO = t_value'(0);
    localparam t_value VAL_ONE  = t_value'(1);
    localparam t_value VAL_ALL  = ~VAL_ZERO;
    localparam t_cnt   CNT_LAST = t_cnt'(VALUE_WIDTH - 1);
    localparam t_cnt   CNT_ZERO = t_cnt'(0);

    typedef struct packed {
        logic start;
    } t_mdu_ctl;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_mdu_sts;

endpackage

// ===== hdl/bc_mdu.sv =====
module bc_mdu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bc_pkg::t_mdu_ctl  i_ctl,
    input  bc_pkg::t_value    i_mcand,
    input  bc_pkg::t_value    i_mplier,
    input  bc_pkg::t_value    i_divisor,
    output bc_pkg::t_mdu_sts  o_sts,
    output bc_pkg::t_value    o_quot
);
    import bc_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_MUL  = 4'b0010,
        M_CHK  = 4'b0100,
        M_DIV  = 4'b1000
    } t_mstate;

    t_mstate r_state, n_state;
    t_value  r_hi, n_hi;
    t_value  r_lo, n_lo;
    t_value  r_mc, n_mc;
    t_value  r_dv, n_dv;
    t_cnt    r_cnt, n_cnt;
    logic    r_done, n_done;
    logic    r_ovf, n_ovf;

    logic [VALUE_WIDTH:0]   mul_sum;
    logic [VALUE_WIDTH:0]   div_sh;
    logic [VALUE_WIDTH+1:0] div_diff;
    logic                   q_bit;

    // shift-add multiply, one multiplier bit per cycle, lsb first
    assign mul_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mc} : {1'b0, VAL_ZERO});

    // restoring divide, one quotient bit per cycle, msb first
    assign div_sh   = {r_hi, r_lo[VALUE_WIDTH-1]};
    assign div_diff = {1'b0, div_sh} - {2'b00, r_dv};
    assign q_bit    = ~div_diff[VALUE_WIDTH+1];

    always_comb begin
        n_state = r_state;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_mc    = r_mc;
        n_dv    = r_dv;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_ovf   = r_ovf;
        unique case (r_state)
            M_IDLE: begin
                if (i_ctl.start) begin
                    n_hi    = VAL_ZERO;
                    n_lo    = i_mplier;
                    n_mc    = i_mcand;
                    n_dv    = i_divisor;
                    n_cnt   = CNT_LAST;
                    n_state = M_MUL;
                end
            end
            M_MUL: begin
                n_hi  = mul_sum[VALUE_WIDTH:1];
                n_lo  = {mul_sum[0], r_lo[VALUE_WIDTH-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_ZERO) begin
                    n_state = M_CHK;
                end
            end
            M_CHK: begin
                // quotient needs more than one word when the high half reaches the divisor
                if (r_hi >= r_dv) begin
                    n_ovf   = 1'b1;
                    n_done  = 1'b1;
                    n_state = M_IDLE;
                end else begin
                    n_ovf   = 1'b0;
                    n_cnt   = CNT_LAST;
                    n_state = M_DIV;
                end
            end
            M_DIV: begin
                n_hi  = q_bit ? div_diff[VALUE_WIDTH-1:0] : div_sh[VALUE_WIDTH-1:0];
                n_lo  = {r_lo[VALUE_WIDTH-2:0], q_bit};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_ZERO) begin
                    n_done  = 1'b1;
                    n_state = M_IDLE;
                end
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_mc  <= n_mc;
        r_dv  <= n_dv;
        r_cnt <= n_cnt;
    end

    assign o_sts.done = r_done;
    assign o_sts.ovf  = r_ovf;
    assign o_quot     = r_lo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == M_IDLE)
        else $error("mdu start while busy");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == M_DIV |-> r_hi < r_dv)
        else $error("partial remainder not below divisor");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == M_IDLE && $past(r_state) != M_MUL)
        else $error("done without finishing a round");

endmodule

// ===== hdl/binomial_coefficient.sv =====
// channel | direction | handshake            | payload
// --------+-----------+----------------------+--------------------------------
// in      | input     | i_valid / o_ready    | i_pool_size, i_choose_count
// out     | output    | o_valid / i_ready    | o_coefficient, o_overflowed
//
// k above n, k zero or k equal to n: result is set in S_PREP with no rounds
// otherwise rounds = min(k, n-k),
// cut short at the first round whose value passes VALUE_WIDTH bits (at most ~34 at 64)
// each round is a bit-serial multiply then a bit-serial restoring divide in bc_mdu
// reset: synchronous active-low i_rst_n clears control state, output channel empties
// a new item is taken while the previous result waits in the output register
module binomial_coefficient (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bc_pkg::t_field i_pool_size,
    input  bc_pkg::t_field i_choose_count,
    output logic           o_valid,
    input  logic           i_ready,
    output bc_pkg::t_field o_coefficient,
    output logic           o_overflowed
);
    import bc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_SEL  = 5'b00100,
        S_STEP = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state   r_state, n_state;
    t_value   r_n, n_n;
    t_value   r_k, n_k;
    t_value   r_b, n_b;
    t_value   r_m, n_m;
    t_value   r_d, n_d;
    t_value   r_left, n_left;
    logic     r_res_ovf, n_res_ovf;
    logic     r_go, n_go;
    logic     r_ovalid, n_ovalid;
    t_value   r_ocoef;
    logic     r_oovf;

    logic [VALUE_WIDTH:0] nk_diff;
    logic                 in_xfer;
    logic                 out_load;
    t_mdu_ctl             mdu_ctl;
    t_mdu_sts             mdu_sts;
    t_value               mdu_quot;

    assign o_ready  = (r_state == S_IDLE);
    assign in_xfer  = i_valid & o_ready;
    assign out_load = (r_state == S_DONE) & (~r_ovalid | i_ready);
    assign nk_diff  = {1'b0, r_n} - {1'b0, r_k};
    assign mdu_ctl.start = r_go;

    bc_mdu u_mdu (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mdu_ctl),
        .i_mcand   (r_b),
        .i_mplier  (r_m),
        .i_divisor (r_d),
        .o_sts     (mdu_sts),
        .o_quot    (mdu_quot)
    );

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_k       = r_k;
        n_b       = r_b;
        n_m       = r_m;
        n_d       = r_d;
        n_left    = r_left;
        n_res_ovf = r_res_ovf;
        n_go      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_n     = i_pool_size[VALUE_WIDTH-1:0];
                    n_k     = i_choose_count[VALUE_WIDTH-1:0];
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_res_ovf = 1'b0;
                if (nk_diff[VALUE_WIDTH]) begin
                    n_b     = VAL_ZERO;
                    n_state = S_DONE;
                end else if (r_k == VAL_ZERO || r_k == r_n) begin
                    n_b     = VAL_ONE;
                    n_state = S_DONE;
                end else begin
                    // hold n-k until the smaller side is picked
                    n_left  = nk_diff[VALUE_WIDTH-1:0];
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                n_left  = (r_left < r_k) ? r_left : r_k;
                n_b     = VAL_ONE;
                n_d     = VAL_ONE;
                n_m     = r_n;
                n_go    = 1'b1;
                n_state = S_STEP;
            end
            S_STEP: begin
                if (mdu_sts.done) begin
                    if (mdu_sts.ovf) begin
                        n_b       = VAL_ALL;
                        n_res_ovf = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        n_b    = mdu_quot;
                        n_left = r_left - VAL_ONE;
                        n_d    = r_d + VAL_ONE;
                        n_m    = r_m - VAL_ONE;
                        if (r_left == VAL_ONE) begin
                            n_state = S_DONE;
                        end else begin
                            n_go = 1'b1;
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_ovalid = out_load | (r_ovalid & ~i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_go     <= n_go;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_k       <= n_k;
        r_b       <= n_b;
        r_m       <= n_m;
        r_d       <= n_d;
        r_left    <= n_left;
        r_res_ovf <= n_res_ovf;
        if (out_load) begin
            r_ocoef <= r_b;
            r_oovf  <= r_res_ovf;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_coefficient = FIELD_WIDTH'(r_ocoef);
    assign o_overflowed  = r_oovf;

    a_step_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STEP |-> r_left != VAL_ZERO)
        else $error("round running with no rounds left");

    a_done_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_sts.done |-> r_state == S_STEP)
        else $error("mdu result outside a round");

    a_sat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_oovf |-> r_ocoef == VAL_ALL)
        else $error("overflow flagged without saturated value");

endmodule
